FILE: sv/tssd_pkg.sv
// Shared types and constants for the tone-score stream decoder.
// Used by the parser front end, the operation queue, the executor and the top level.
package tssd_pkg;

  localparam int NUM_GENERATORS = 6;
  localparam int SHOWN_GENS     = 6;
  localparam int GEN_W          = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
  localparam int NOTE_W         = 8;
  localparam int DELAY_W        = 15;
  localparam int TIME_W         = 32;
  localparam int USED_W         = 3;
  localparam int COUNT_W        = 4;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = 2;

  localparam logic [NOTE_W-1:0] NOTE_SILENT = 8'd128;
  localparam logic [USED_W-1:0] USED_MAX    = 3'd7;

  // High nibble of a command byte
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_NOP      = 4'hF;

  // Result kinds
  localparam logic [1:0] EV_STATUS = 2'd0;
  localparam logic [1:0] EV_FINAL  = 2'd1;
  localparam logic [1:0] EV_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_GEN   = 3'd1;
  localparam logic [2:0] ERR_BAD_NOTE  = 3'd2;
  localparam logic [2:0] ERR_NOT_ON    = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_DELAY_LO,
    PH_NOTE
  } phase_t;

  typedef enum logic [2:0] {
    OP_DELAY,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_FINISH,
    OP_ERROR
  } op_kind_t;

  // One classified operation handed from the parser to the executor
  typedef struct packed {
    op_kind_t           kind;
    logic [GEN_W-1:0]   gen;
    logic [DELAY_W-1:0] value;  // delay, or note in the low bits
    logic [2:0]         err;
    logic               last;
  } op_t;

endpackage

FILE: sv/tone_score_stream_decoder.sv
// Top level of the tone-score stream decoder: parser, operation queue, executor.
// Depends on tssd_pkg, tssd_front, tssd_fifo and tssd_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one score byte per transfer on data_byte,
//   end_of_stream high on the last byte. Bytes are taken every cycle while the
//   four-entry operation queue has room; in_stall is high only when it is full.
//   Output channel (out_valid / out_stall): one row per transfer. A status row
//   comes out for every complete delay, a final row at stream end, an error row
//   on a malformed stream. After a final or error row the block halts: bytes are
//   still taken and dropped until reset.
//   Row path: the byte that completes a row is written into the queue, then the
//   executor pops it and registers the row in its output register, waiting while
//   a held row is stalled.
//   Throughput: one byte per cycle unless in_stall; the executor retires one queued
//   operation per unstalled cycle, and the elapsed-time add is its longest path.
//   Receiver stall: the output register holds its row, the executor stops
//   popping, the queue fills, and then in_stall rises. No operation retires
//   while the output holds, whether or not it yields a row.
//   Reset (rst, synchronous, active high): all generators silent, time zero,
//   used mask cleared, queue emptied, parser back to expecting a command byte.
module tone_score_stream_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_kind,
  output logic [2:0]                    error_code,
  output logic [tssd_pkg::DELAY_W-1:0]  delay_ms,
  output logic [tssd_pkg::TIME_W-1:0]   time_ms,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen0,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen1,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen2,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen3,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen4,
  output logic [tssd_pkg::NOTE_W-1:0]   note_gen5,
  output logic [tssd_pkg::USED_W-1:0]   generators_used
);
  import tssd_pkg::*;

  logic              take;
  logic              push;
  op_t               push_op;
  logic              q_full;
  logic              q_avail;
  op_t               q_head;
  logic              pop;
  logic [NOTE_W-1:0] row_notes [SHOWN_GENS];

  // Accept whenever the queue has room, even while the output is held
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // Classify each byte into an operation
  tssd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .push          (push),
    .op            (push_op)
  );

  // Decouple parser from executor
  tssd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_avail),
    .head      (q_head)
  );

  // Apply operations and register the result row
  tssd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .op_avail        (q_avail),
    .op              (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .error_code      (error_code),
    .delay_ms        (delay_ms),
    .time_ms         (time_ms),
    .row_notes       (row_notes),
    .generators_used (generators_used)
  );

  assign note_gen0 = row_notes[0];
  assign note_gen1 = row_notes[1];
  assign note_gen2 = row_notes[2];
  assign note_gen3 = row_notes[3];
  assign note_gen4 = row_notes[4];
  assign note_gen5 = row_notes[5];

endmodule

FILE: sv/tssd_front.sv
// Parser front end: assembles delays and note commands from the byte stream
// and classifies them into operations. Depends on tssd_pkg.
module tssd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          end_of_stream,
  output logic          push,
  output tssd_pkg::op_t op
);
  import tssd_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic [6:0]         pending_high;
  logic [GEN_W-1:0]   pending_gen;
  logic               halted;
  logic               op_valid;
  logic               bad_gen;
  logic [3:0]         cmd;

  assign cmd     = data_byte[7:4];
  assign bad_gen = data_byte[3:0] >= 4'(NUM_GENERATORS);

  // Next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_CMD: begin
        if (!data_byte[7]) begin
          if (!end_of_stream) phase_next = PH_DELAY_LO;
        end else if (!bad_gen && cmd == CMD_NOTE_ON && !end_of_stream) begin
          phase_next = PH_NOTE;
        end
      end
      PH_DELAY_LO: phase_next = PH_CMD;
      PH_NOTE:     phase_next = PH_CMD;
      default:     phase_next = PH_CMD;
    endcase
  end

  // Operation produced by this byte
  always_comb begin
    op_valid = 1'b0;
    op.kind  = OP_ERROR;
    op.gen   = data_byte[GEN_W-1:0];
    op.value = {{(DELAY_W-8){1'b0}}, data_byte};
    op.err   = ERR_NONE;
    op.last  = end_of_stream;
    case (phase)
      PH_CMD: begin
        if (!data_byte[7]) begin
          if (end_of_stream) begin
            op_valid = 1'b1;
            op.err   = ERR_TRUNCATED;
          end
        end else if (bad_gen) begin
          op_valid = 1'b1;
          op.err   = ERR_BAD_GEN;
        end else begin
          case (cmd)
            CMD_NOTE_ON: begin
              if (end_of_stream) begin
                op_valid = 1'b1;
                op.err   = ERR_TRUNCATED;
              end
            end
            CMD_NOTE_OFF: begin
              op_valid = 1'b1;
              op.kind  = OP_NOTE_OFF;
            end
            CMD_NOP: begin
              op_valid = end_of_stream;
              op.kind  = OP_FINISH;
            end
            default: begin
              op_valid = 1'b1;
              op.err   = ERR_UNKNOWN;
            end
          endcase
        end
      end
      PH_DELAY_LO: begin
        op_valid = 1'b1;
        op.kind  = OP_DELAY;
        op.value = {pending_high, data_byte};
      end
      PH_NOTE: begin
        op_valid = 1'b1;
        op.gen   = pending_gen;
        if (data_byte[7]) begin
          op.err = ERR_BAD_NOTE;
        end else begin
          op.kind = OP_NOTE_ON;
        end
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  assign push = take && !halted && op_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_CMD;
      halted <= 1'b0;
    end else if (take && !halted) begin
      phase <= phase_next;
      // Every last byte and every parse error ends the stream
      if (end_of_stream || (op_valid && op.kind == OP_ERROR)) halted <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= '0;
      pending_gen  <= '0;
    end else if (take && !halted && phase == PH_CMD) begin
      if (!data_byte[7]) pending_high <= data_byte[6:0];
      else if (cmd == CMD_NOTE_ON) pending_gen <= data_byte[GEN_W-1:0];
    end
  end

  // Nothing leaves the front end once it has halted
  assert property (@(posedge clk) disable iff (rst) halted |-> !push)
    else $error("front end pushed after halt");
  // A delay operation only follows a delay high byte
  assert property (@(posedge clk) disable iff (rst)
    (push && op.kind == OP_DELAY) |-> phase == PH_DELAY_LO)
    else $error("delay issued outside delay phase");
  // A last byte always halts the parser
  assert property (@(posedge clk) disable iff (rst)
    (take && !halted && end_of_stream) |=> halted)
    else $error("parser did not halt at stream end");

endmodule

FILE: sv/tssd_fifo.sv
// Short operation queue between parser and executor.
// Depends on tssd_pkg for the operation type and depth.
module tssd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tssd_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output tssd_pkg::op_t head
);
  import tssd_pkg::*;

  op_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full      = count == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
    else $error("queue count over depth");
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("pop from empty queue");

endmodule

FILE: sv/tssd_back.sv
// Executor: applies queued operations to generator notes, elapsed time and the
// used mask, and holds the result row in an output register. Depends on tssd_pkg.
module tssd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          op_avail,
  input  tssd_pkg::op_t                 op,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_kind,
  output logic [2:0]                    error_code,
  output logic [tssd_pkg::DELAY_W-1:0]  delay_ms,
  output logic [tssd_pkg::TIME_W-1:0]   time_ms,
  output logic [tssd_pkg::NOTE_W-1:0]   row_notes [tssd_pkg::SHOWN_GENS],
  output logic [tssd_pkg::USED_W-1:0]   generators_used
);
  import tssd_pkg::*;

  logic [NOTE_W-1:0]         notes      [NUM_GENERATORS];
  logic [NOTE_W-1:0]         notes_next [NUM_GENERATORS];
  logic [NUM_GENERATORS-1:0] used;
  logic [NUM_GENERATORS-1:0] used_next;
  logic [TIME_W-1:0]         elapsed;
  logic [TIME_W-1:0]         elapsed_next;
  logic                      halted;
  logic                      halted_next;
  logic                      emit;
  logic [1:0]                kind_c;
  logic [2:0]                err_c;
  logic [DELAY_W-1:0]        delay_c;
  logic                      show_used;
  logic [COUNT_W-1:0]        used_cnt;
  logic [USED_W-1:0]         used_sat;

  assign pop = op_avail && (!out_valid || !out_stall);

  always_comb begin
    notes_next   = notes;
    used_next    = used;
    elapsed_next = elapsed;
    halted_next  = halted;
    emit         = 1'b0;
    kind_c       = EV_STATUS;
    err_c        = ERR_NONE;
    delay_c      = '0;
    show_used    = 1'b0;
    if (pop && !halted) begin
      case (op.kind)
        OP_DELAY: begin
          emit         = 1'b1;
          delay_c      = op.value;
          elapsed_next = elapsed + {{(TIME_W-DELAY_W){1'b0}}, op.value};
          if (op.last) begin
            kind_c      = EV_FINAL;
            show_used   = 1'b1;
            halted_next = 1'b1;
          end
        end
        OP_NOTE_ON: begin
          notes_next[op.gen] = op.value[NOTE_W-1:0];
          used_next[op.gen]  = 1'b1;
          if (op.last) begin
            emit        = 1'b1;
            kind_c      = EV_FINAL;
            show_used   = 1'b1;
            halted_next = 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          if (notes[op.gen] == NOTE_SILENT) begin
            emit        = 1'b1;
            kind_c      = EV_ERROR;
            err_c       = ERR_NOT_ON;
            halted_next = 1'b1;
          end else begin
            notes_next[op.gen] = NOTE_SILENT;
            if (op.last) begin
              emit        = 1'b1;
              kind_c      = EV_FINAL;
              show_used   = 1'b1;
              halted_next = 1'b1;
            end
          end
        end
        OP_FINISH: begin
          emit        = 1'b1;
          kind_c      = EV_FINAL;
          show_used   = 1'b1;
          halted_next = 1'b1;
        end
        OP_ERROR: begin
          emit        = 1'b1;
          kind_c      = EV_ERROR;
          err_c       = op.err;
          halted_next = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // Count of generators ever on, saturated to the field width
  always_comb begin
    used_cnt = '0;
    for (int i = 0; i < NUM_GENERATORS; i++) begin
      used_cnt = used_cnt + COUNT_W'(used_next[i]);
    end
    used_sat = (used_cnt > COUNT_W'(USED_MAX)) ? USED_MAX : used_cnt[USED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GENERATORS; i++) notes[i] <= NOTE_SILENT;
      used    <= '0;
      elapsed <= '0;
      halted  <= 1'b0;
    end else begin
      notes   <= notes_next;
      used    <= used_next;
      elapsed <= elapsed_next;
      halted  <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind      <= kind_c;
      error_code      <= err_c;
      delay_ms        <= delay_c;
      time_ms         <= elapsed;
      generators_used <= show_used ? used_sat : '0;
      for (int i = 0; i < SHOWN_GENS; i++) begin
        row_notes[i] <= (i < NUM_GENERATORS) ? notes_next[i] : NOTE_SILENT;
      end
    end
  end

  // Once halted, a delivered row is never followed by another
  assert property (@(posedge clk) disable iff (rst)
    (halted && out_valid && !out_stall) |=> !out_valid)
    else $error("row issued after halt");
  // Error rows carry no delay and no used count
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_ERROR) |-> (delay_ms == '0 && generators_used == '0))
    else $error("error row carries delay or count");
  // Status rows carry no used count
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_STATUS) |-> generators_used == '0)
    else $error("status row carries used count");
  // Final and error rows halt the executor
  assert property (@(posedge clk) disable iff (rst)
    (emit && kind_c != EV_STATUS) |=> halted)
    else $error("executor did not halt after terminal row");

endmodule

FILE: tb/score_row_checker.sv
// Row checker for the tone-score stream decoder: watches both channels and predicts rows.
// Scores every row against its prediction. Depends on tssd_pkg.
`timescale 1ns / 1ps

module score_row_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_stream,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   event_kind,
  input  logic [2:0]                   error_code,
  input  logic [tssd_pkg::DELAY_W-1:0] delay_ms,
  input  logic [tssd_pkg::TIME_W-1:0]  time_ms,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen0,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen1,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen2,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen3,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen4,
  input  logic [tssd_pkg::NOTE_W-1:0]  note_gen5,
  input  logic [tssd_pkg::USED_W-1:0]  generators_used,
  output int                           mismatches,
  output int                           outstanding
);
  import tssd_pkg::*;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 8'd127;

  typedef struct packed {
    logic [1:0]                        kind;
    logic [2:0]                        err;
    logic [DELAY_W-1:0]                delay;
    logic [TIME_W-1:0]                 start;
    logic [SHOWN_GENS-1:0][NOTE_W-1:0] notes;
    logic [USED_W-1:0]                 used;
  } score_row_t;

  // Decoder state as predicted
  phase_t                     phase;
  logic [6:0]                 pend_high;
  logic [GEN_W-1:0]           pend_gen;
  logic [NOTE_W-1:0]          gen_note [NUM_GENERATORS];
  logic [TIME_W-1:0]          elapsed;
  logic [NUM_GENERATORS-1:0]  used_mask;
  bit                         halted;

  score_row_t rows_due [$];
  score_row_t seen, want, row;
  int         rows_checked = 0;

  function automatic void clear_model();
    phase     = PH_CMD;
    pend_high = '0;
    pend_gen  = '0;
    for (int i = 0; i < NUM_GENERATORS; i++) gen_note[i] = NOTE_SILENT;
    elapsed   = '0;
    used_mask = '0;
    halted    = 1'b0;
  endfunction

  function automatic logic [USED_W-1:0] used_total();
    int n;
    n = 0;
    for (int i = 0; i < NUM_GENERATORS; i++) n += used_mask[i];
    return (n > USED_MAX) ? USED_MAX : USED_W'(n);
  endfunction

  function automatic score_row_t make_row(input logic [1:0] kind, input logic [2:0] err,
                                          input logic [DELAY_W-1:0] span,
                                          input logic [TIME_W-1:0] start,
                                          input logic [USED_W-1:0] used);
    score_row_t r;
    r.kind  = kind;
    r.err   = err;
    r.delay = span;
    r.start = start;
    for (int i = 0; i < SHOWN_GENS; i++)
      r.notes[i] = (i < NUM_GENERATORS) ? gen_note[i] : NOTE_SILENT;
    r.used  = used;
    return r;
  endfunction

  // Final and error rows both freeze the decoder until reset
  function automatic score_row_t stop_row(input logic [1:0] kind, input logic [2:0] err);
    halted = 1'b1;
    return make_row(kind, err, '0, elapsed, (kind == EV_FINAL) ? used_total() : '0);
  endfunction

  // Advance the predicted state by one byte; return 1 when the byte yields a row
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output score_row_t r);
    logic [DELAY_W-1:0] span;
    logic [TIME_W-1:0]  start;
    logic [3:0]         g;
    r = '0;
    if (halted) return 1'b0;
    if (phase == PH_DELAY_LO) begin
      span    = {pend_high, b};
      start   = elapsed;
      phase   = PH_CMD;
      elapsed = elapsed + span;
      if (last) begin
        halted = 1'b1;
        r = make_row(EV_FINAL, ERR_NONE, span, start, used_total());
      end else begin
        r = make_row(EV_STATUS, ERR_NONE, span, start, '0);
      end
      return 1'b1;
    end
    if (phase == PH_NOTE) begin
      phase = PH_CMD;
      if (b > NOTE_MAX) begin
        r = stop_row(EV_ERROR, ERR_BAD_NOTE);
        return 1'b1;
      end
      gen_note[pend_gen]  = b;
      used_mask[pend_gen] = 1'b1;
      if (last) r = stop_row(EV_FINAL, ERR_NONE);
      return last;
    end
    if (!b[7]) begin
      if (last) begin
        r = stop_row(EV_ERROR, ERR_TRUNCATED);
        return 1'b1;
      end
      pend_high = b[6:0];
      phase     = PH_DELAY_LO;
      return 1'b0;
    end
    g = b[3:0];
    if (g >= NUM_GENERATORS) begin
      r = stop_row(EV_ERROR, ERR_BAD_GEN);
      return 1'b1;
    end
    if (b[7:4] == CMD_NOTE_ON) begin
      if (last) begin
        r = stop_row(EV_ERROR, ERR_TRUNCATED);
        return 1'b1;
      end
      pend_gen = g[GEN_W-1:0];
      phase    = PH_NOTE;
      return 1'b0;
    end
    if (b[7:4] == CMD_NOTE_OFF) begin
      if (gen_note[g] == NOTE_SILENT) begin
        r = stop_row(EV_ERROR, ERR_NOT_ON);
        return 1'b1;
      end
      gen_note[g] = NOTE_SILENT;
    end else if (b[7:4] != CMD_NOP) begin
      r = stop_row(EV_ERROR, ERR_UNKNOWN);
      return 1'b1;
    end
    if (last) r = stop_row(EV_FINAL, ERR_NONE);
    return last;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t row checker: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [31:0] got, input logic [31:0] wanted);
    if (got !== wanted)
      flag_mismatch($sformatf("row %0d %s got %0h, wanted %0h", idx, name, got, wanted));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      rows_due.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen.kind     = event_kind;
        seen.err      = error_code;
        seen.delay    = delay_ms;
        seen.start    = time_ms;
        seen.notes[0] = note_gen0;
        seen.notes[1] = note_gen1;
        seen.notes[2] = note_gen2;
        seen.notes[3] = note_gen3;
        seen.notes[4] = note_gen4;
        seen.notes[5] = note_gen5;
        seen.used     = generators_used;
        if (rows_due.size() == 0) begin
          flag_mismatch($sformatf("row %0d arrived with none due", rows_checked));
        end else begin
          want = rows_due.pop_front();
          check_field("event_kind", rows_checked, seen.kind, want.kind);
          check_field("error_code", rows_checked, seen.err, want.err);
          check_field("delay_ms", rows_checked, seen.delay, want.delay);
          check_field("time_ms", rows_checked, seen.start, want.start);
          for (int i = 0; i < SHOWN_GENS; i++)
            check_field($sformatf("note_gen%0d", i), rows_checked, seen.notes[i],
                        want.notes[i]);
          check_field("generators_used", rows_checked, seen.used, want.used);
        end
        rows_checked++;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (decode_byte(data_byte, end_of_stream, row)) rows_due.push_back(row);
      end
    end
    outstanding = rows_due.size();
  end

endmodule

FILE: tb/tb_tone_score_stream_decoder.sv
// Top of the tone-score stream decoder bench: clock, reset, byte stimulus, verdict.
// Depends on tssd_pkg, tone_score_stream_decoder and score_row_checker.
`timescale 1ns / 1ps

module tb_tone_score_stream_decoder;
  import tssd_pkg::*;

  // How the single stream of the run is closed off; only one per run, since
  // the decoder halts after its first final or error row.
  typedef enum int {
    END_ON_DELAY,
    END_ON_NOTE,
    END_ON_OFF,
    END_ON_NOP,
    CLOSE_BAD_GEN,
    CLOSE_BAD_NOTE,
    CLOSE_OFF_SILENT,
    CLOSE_UNKNOWN_CMD,
    CLOSE_CUT_DELAY,
    CLOSE_CUT_NOTE_ON
  } stream_close_t;

  localparam int RANDOM_BYTES = 1200;
  localparam int IDLE_PCT     = 23;
  localparam int DRAIN_LIMIT  = 5000;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte     = 8'h00;
  logic                 end_of_stream = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [1:0]           event_kind;
  logic [2:0]           error_code;
  logic [DELAY_W-1:0]   delay_ms;
  logic [TIME_W-1:0]    time_ms;
  logic [NOTE_W-1:0]    note_gen0, note_gen1, note_gen2;
  logic [NOTE_W-1:0]    note_gen3, note_gen4, note_gen5;
  logic [USED_W-1:0]    generators_used;
  int                   mismatches;
  int                   outstanding;

  // Stimulus bookkeeping only: which generators are sounding, so that the
  // well-formed part never turns off a silent one, and the time sent so far.
  bit                        calm      = 1'b0;
  bit [NUM_GENERATORS-1:0]   gen_lit   = '0;
  longint unsigned           sent_time = 0;
  int                        bytes_sent = 0;

  tone_score_stream_decoder uut (.*);

  score_row_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: stall about a quarter of the time, never while calm
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Hang guard: far beyond the slowest correct run
  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Present one byte and hold it until the transfer happens. Idle cycles go
  // in front of the byte, so valid stays high across back-to-back transfers.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Delay: high seven bits first, then the low byte
  task automatic send_delay(input logic [DELAY_W-1:0] span, input logic last);
    send_byte({1'b0, span[14:8]}, 1'b0);
    send_byte(span[7:0], last);
    sent_time += span;
  endtask

  task automatic send_on(input logic [3:0] g, input logic [7:0] note, input logic last);
    send_byte({CMD_NOTE_ON, g}, 1'b0);
    send_byte(note, last);
    gen_lit[g] = 1'b1;
  endtask

  task automatic send_off(input logic [3:0] g, input logic last);
    send_byte({CMD_NOTE_OFF, g}, last);
    gen_lit[g] = 1'b0;
  endtask

  task automatic send_nop(input logic [3:0] g, input logic last);
    send_byte({CMD_NOP, g}, last);
  endtask

  // Drop valid and hold until every predicted row has been seen or the limit
  // runs out; sample the count on the falling edge, away from the checker's update.
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
    @(posedge clk);
  endtask

  function automatic logic [3:0] pick_gen(input bit lit);
    logic [3:0] g;
    do g = 4'($urandom_range(NUM_GENERATORS - 1)); while (gen_lit[g] != lit);
    return g;
  endfunction

  // Favor the edges of the delay range, keep plenty of uniform values too
  function automatic logic [DELAY_W-1:0] random_delay();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DELAY_W'($urandom_range(255));
      default: return DELAY_W'($urandom);
    endcase
  endfunction

  initial begin
    int            pick;
    int            stop_at;
    logic [3:0]    g;
    stream_close_t how;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: extreme delays, extreme notes and generators, every
    // command, bit patterns across both delay bytes.
    send_delay(15'h0000, 1'b0);
    send_delay(15'h7FFF, 1'b0);
    send_on(4'd0, 8'd0, 1'b0);
    send_on(4'(NUM_GENERATORS - 1), 8'd127, 1'b0);
    send_delay(15'h2A55, 1'b0);
    send_nop(4'd0, 1'b0);
    send_nop(4'(NUM_GENERATORS - 1), 1'b0);
    send_on(4'd3, 8'h55, 1'b0);
    send_delay(15'h55AA, 1'b0);
    send_off(4'd0, 1'b0);
    send_off(4'(NUM_GENERATORS - 1), 1'b0);
    send_delay(15'd1, 1'b0);

    // Hold the sender until the decoder has caught up
    drain(DRAIN_LIMIT);

    // Long stretch with no idling on either side: about a hundred maximum
    // delays back to back.
    calm = 1'b1;
    while (sent_time < 64'd3_300_000) send_delay('1, 1'b0);
    calm = 1'b0;

    // Random well-formed score; pause halfway for everything to drain
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= stop_at - RANDOM_BYTES / 2 && bytes_sent < stop_at - RANDOM_BYTES / 2 + 2)
        drain(DRAIN_LIMIT);
      pick = $urandom_range(19);
      if (pick < 9) begin
        send_delay(random_delay(), 1'b0);
      end else if (pick < 14) begin
        send_on(4'($urandom_range(NUM_GENERATORS - 1)), 8'($urandom_range(127)), 1'b0);
      end else if (pick < 17 && gen_lit != '0) begin
        send_off(pick_gen(1'b1), 1'b0);
      end else begin
        send_nop(4'($urandom_range(NUM_GENERATORS - 1)), 1'b0);
      end
    end

    // Close the stream: a clean end or one of the faults, chosen at random
    how = stream_close_t'($urandom_range(9));
    case (how)
      END_ON_DELAY:  send_delay(random_delay(), 1'b1);
      END_ON_NOTE:   send_on(4'($urandom_range(NUM_GENERATORS - 1)),
                             8'($urandom_range(127)), 1'b1);
      END_ON_OFF: begin
        if (gen_lit == '0) send_on(4'($urandom_range(NUM_GENERATORS - 1)), 8'd60, 1'b0);
        send_off(pick_gen(1'b1), 1'b1);
      end
      END_ON_NOP:    send_nop(4'($urandom_range(NUM_GENERATORS - 1)), 1'b1);
      CLOSE_BAD_GEN: send_byte({4'($urandom_range(15, 8)),
                                4'($urandom_range(15, NUM_GENERATORS))}, 1'($urandom));
      CLOSE_BAD_NOTE: begin
        send_byte({CMD_NOTE_ON, 4'($urandom_range(NUM_GENERATORS - 1))}, 1'b0);
        send_byte({1'b1, 7'($urandom)}, 1'($urandom));
      end
      CLOSE_OFF_SILENT: begin
        if (&gen_lit) send_off(4'($urandom_range(NUM_GENERATORS - 1)), 1'b0);
        g = pick_gen(1'b0);
        send_byte({CMD_NOTE_OFF, g}, 1'($urandom));
      end
      CLOSE_UNKNOWN_CMD: send_byte({4'($urandom_range(14, 10)),
                                    4'($urandom_range(NUM_GENERATORS - 1))}, 1'($urandom));
      CLOSE_CUT_DELAY:   send_byte({1'b0, 7'($urandom)}, 1'b1);
      default:           send_byte({CMD_NOTE_ON, 4'($urandom_range(NUM_GENERATORS - 1))},
                                   1'b1);
    endcase

    // Trailing bytes must be swallowed by the halted decoder
    repeat (6) send_byte(8'($urandom), 1'($urandom));

    // Drain, then allow the pipeline depth for any stray row
    drain(DRAIN_LIMIT);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
